FILE: rtl/ubx_frame_parser_core_defines.svh
// ---------------------------------------------------------------------------
// UBX frame parser core assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and reset by rst_ni.
// ---------------------------------------------------------------------------
`ifndef UBX_FRAME_PARSER_CORE_DEFINES_SVH
`define UBX_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication
`define UBX_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define UBX_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ubxfp_pkg.sv
// ---------------------------------------------------------------------------
// UBX frame parser package
// Parser phase codes, sync constants and the result record.
// ---------------------------------------------------------------------------
package ubxfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC1   = 4'd1,
    PH_SYNC2   = 4'd2,
    PH_CLASS   = 4'd3,
    PH_ID      = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8,
    PH_DONE    = 4'd9
  } phase_e;

  typedef struct packed {
    logic [3:0]  phase;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
    logic        checksum_error;
  } result_t;

endpackage

FILE: rtl/ubx_frame_parser_core.sv
// Each accepted byte's result is registered in the result register, or in the skid register when the output is stalled.
// One byte per cycle while in_stall_o is low; the parser state updates in a single step per byte.
// A two-entry output stage (result register plus skid register) keeps input flowing.
// Reset clears the parser phase, checksums, header registers and the output valids.
// ---------------------------------------------------------------------------
// UBX frame parser core
// Hunts for sync, captures the header, forwards payload bytes with their
// index and checks the Fletcher-8 checksum, one byte per transaction.
// ---------------------------------------------------------------------------
`include "ubx_frame_parser_core_defines.svh"

module ubx_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  phase_o,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] msg_length_o,
  output logic        checksum_error_o
);

  ubxfp_pkg::phase_e  phase_q, phase_d;
  logic [7:0]         sum_a_q, sum_a_d;
  logic [7:0]         sum_b_q, sum_b_d;
  logic [7:0]         class_q, class_d;
  logic [7:0]         id_q, id_d;
  logic [15:0]        len_q, len_d;
  logic [15:0]        idx_q, idx_d;

  ubxfp_pkg::result_t res_d;
  ubxfp_pkg::result_t out_q, skid_q;
  logic               out_vld_q, skid_vld_q;

  logic               accept;
  logic               out_take;
  logic [7:0]         acc_a;
  logic [7:0]         acc_b;
  logic [15:0]        idx_inc;

  assign in_stall_o = skid_vld_q;
  assign accept     = in_valid_i && !skid_vld_q;
  assign out_take   = out_vld_q && !out_stall_i;

  assign acc_a   = sum_a_q + rx_byte_i;
  assign acc_b   = sum_b_q + acc_a;
  assign idx_inc = idx_q + 16'd1;

  // Next state
  always_comb begin
    phase_d = ubxfp_pkg::PH_HUNT;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    idx_d   = idx_q;
    unique case (phase_q)
      ubxfp_pkg::PH_SYNC1: begin
        if (rx_byte_i == ubxfp_pkg::SYNC_SECOND) begin
          phase_d = ubxfp_pkg::PH_SYNC2;
          sum_a_d = '0;
          sum_b_d = '0;
        end
      end
      ubxfp_pkg::PH_SYNC2: begin
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        class_d = rx_byte_i;
        phase_d = ubxfp_pkg::PH_CLASS;
      end
      ubxfp_pkg::PH_CLASS: begin
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        id_d    = rx_byte_i;
        phase_d = ubxfp_pkg::PH_ID;
      end
      ubxfp_pkg::PH_ID: begin
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        len_d   = {8'd0, rx_byte_i};
        phase_d = ubxfp_pkg::PH_LEN_LO;
      end
      ubxfp_pkg::PH_LEN_LO: begin
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        len_d   = {rx_byte_i, len_q[7:0]};
        idx_d   = '0;
        // Empty payload skips straight to the checksum
        phase_d = ({rx_byte_i, len_q[7:0]} == 16'd0) ? ubxfp_pkg::PH_CK_A
                                                      : ubxfp_pkg::PH_PAYLOAD;
      end
      ubxfp_pkg::PH_PAYLOAD: begin
        sum_a_d = acc_a;
        sum_b_d = acc_b;
        idx_d   = idx_inc;
        phase_d = (idx_inc >= len_q) ? ubxfp_pkg::PH_CK_A : ubxfp_pkg::PH_PAYLOAD;
      end
      ubxfp_pkg::PH_CK_A: begin
        phase_d = (rx_byte_i == sum_a_q) ? ubxfp_pkg::PH_CK_B : ubxfp_pkg::PH_HUNT;
      end
      ubxfp_pkg::PH_CK_B: begin
        phase_d = (rx_byte_i == sum_b_q) ? ubxfp_pkg::PH_DONE : ubxfp_pkg::PH_HUNT;
      end
      default: begin
        // Hunt, frame done and unused codes all look for the first sync byte
        phase_d = (rx_byte_i == ubxfp_pkg::SYNC_FIRST) ? ubxfp_pkg::PH_SYNC1
                                                       : ubxfp_pkg::PH_HUNT;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_d.phase          = phase_d;
    res_d.payload_valid  = (phase_q == ubxfp_pkg::PH_PAYLOAD);
    res_d.payload_byte   = (phase_q == ubxfp_pkg::PH_PAYLOAD) ? rx_byte_i : 8'd0;
    res_d.payload_index  = (phase_q == ubxfp_pkg::PH_PAYLOAD) ? idx_q : 16'd0;
    res_d.msg_class      = class_d;
    res_d.msg_id         = id_d;
    res_d.msg_length     = len_d;
    res_d.checksum_error = ((phase_q == ubxfp_pkg::PH_CK_A) && (rx_byte_i != sum_a_q)) ||
                           ((phase_q == ubxfp_pkg::PH_CK_B) && (rx_byte_i != sum_b_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ubxfp_pkg::PH_HUNT;
      sum_a_q <= '0;
      sum_b_q <= '0;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_vld_q || out_take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_vld_q || out_take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign phase_o          = out_q.phase;
  assign payload_valid_o  = out_q.payload_valid;
  assign payload_byte_o   = out_q.payload_byte;
  assign payload_index_o  = out_q.payload_index;
  assign msg_class_o      = out_q.msg_class;
  assign msg_id_o         = out_q.msg_id;
  assign msg_length_o     = out_q.msg_length;
  assign checksum_error_o = out_q.checksum_error;

  `UBX_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q,
                  "skid entry held while result register empty")
  `UBX_ASSERT_NOW(a_payload_phase, out_vld_q && out_q.payload_valid,
                  (out_q.phase == ubxfp_pkg::PH_PAYLOAD) ||
                  (out_q.phase == ubxfp_pkg::PH_CK_A),
                  "payload byte reported outside payload")
  `UBX_ASSERT_NOW(a_cksum_err_hunt, out_vld_q && out_q.checksum_error,
                  out_q.phase == ubxfp_pkg::PH_HUNT,
                  "checksum error without return to hunt")
  `UBX_ASSERT_NEXT(a_frame_done,
                   accept && (phase_q == ubxfp_pkg::PH_CK_B) && (rx_byte_i == sum_b_q),
                   phase_q == ubxfp_pkg::PH_DONE,
                   "matching second checksum byte did not complete the frame")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// UBX frame parser core testbench
// Streams directed and random byte sequences (good frames, corrupted
// checksums and payloads, broken sync, noise) through the parser with random
// gaps and output stalls. Every result is checked against a byte-level parser
// model kept in the testbench.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned NUM_BYTES   = 750;
  localparam int unsigned WDOG_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    FR_GOOD,
    FR_BAD_CKA,
    FR_BAD_CKB,
    FR_BAD_PAYLOAD
  } frame_fault_e;

  typedef struct {
    logic [7:0]  data;
    int unsigned gap;
    bit          drain;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [3:0]  phase_o;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic [7:0]  msg_class_o;
  logic [7:0]  msg_id_o;
  logic [15:0] msg_length_o;
  logic        checksum_error_o;

  ubx_frame_parser_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .phase_o          (phase_o),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .msg_class_o      (msg_class_o),
    .msg_id_o         (msg_id_o),
    .msg_length_o     (msg_length_o),
    .checksum_error_o (checksum_error_o)
  );

  always #5 clk_i = ~clk_i;

  // Parser model state
  ubxfp_pkg::phase_e prs_phase = ubxfp_pkg::PH_HUNT;
  logic [7:0]  run_a     = '0;
  logic [7:0]  run_b     = '0;
  logic [7:0]  hdr_class = '0;
  logic [7:0]  hdr_id    = '0;
  logic [15:0] hdr_len   = '0;
  logic [15:0] pay_cnt   = '0;

  rx_item_t           rx_q[$];
  ubxfp_pkg::result_t parse_q[$];

  bit          sender_idle = 1'b0;
  bit          sink_idle   = 1'b0;
  int unsigned hold_off    = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_queued    = 0;
  int unsigned n_errors    = 0;
  int unsigned n_results   = 0;
  int unsigned n_complete  = 0;
  int unsigned n_ck_errors = 0;
  int unsigned n_payload   = 0;

  function automatic void fold_sum(logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endfunction

  // Advance the parser by one byte and return the result it produces.
  function automatic ubxfp_pkg::result_t parse_byte(logic [7:0] b);
    ubxfp_pkg::result_t r;
    r = '0;
    case (prs_phase)
      ubxfp_pkg::PH_SYNC1: begin
        if (b == ubxfp_pkg::SYNC_SECOND) begin
          prs_phase = ubxfp_pkg::PH_SYNC2;
          run_a = '0;
          run_b = '0;
        end else begin
          prs_phase = ubxfp_pkg::PH_HUNT;
        end
      end
      ubxfp_pkg::PH_SYNC2: begin
        fold_sum(b);
        hdr_class = b;
        prs_phase = ubxfp_pkg::PH_CLASS;
      end
      ubxfp_pkg::PH_CLASS: begin
        fold_sum(b);
        hdr_id = b;
        prs_phase = ubxfp_pkg::PH_ID;
      end
      ubxfp_pkg::PH_ID: begin
        fold_sum(b);
        hdr_len = {8'h00, b};
        prs_phase = ubxfp_pkg::PH_LEN_LO;
      end
      ubxfp_pkg::PH_LEN_LO: begin
        fold_sum(b);
        hdr_len = {b, hdr_len[7:0]};
        pay_cnt = '0;
        prs_phase = (hdr_len == 16'd0) ? ubxfp_pkg::PH_CK_A
                                       : ubxfp_pkg::PH_PAYLOAD;
      end
      ubxfp_pkg::PH_PAYLOAD: begin
        fold_sum(b);
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = pay_cnt;
        pay_cnt = pay_cnt + 16'd1;
        if (pay_cnt >= hdr_len) prs_phase = ubxfp_pkg::PH_CK_A;
      end
      ubxfp_pkg::PH_CK_A: begin
        if (b == run_a) begin
          prs_phase = ubxfp_pkg::PH_CK_B;
        end else begin
          prs_phase = ubxfp_pkg::PH_HUNT;
          r.checksum_error = 1'b1;
        end
      end
      ubxfp_pkg::PH_CK_B: begin
        if (b == run_b) begin
          prs_phase = ubxfp_pkg::PH_DONE;
        end else begin
          prs_phase = ubxfp_pkg::PH_HUNT;
          r.checksum_error = 1'b1;
        end
      end
      default: begin
        prs_phase = (b == ubxfp_pkg::SYNC_FIRST) ? ubxfp_pkg::PH_SYNC1
                                                 : ubxfp_pkg::PH_HUNT;
      end
    endcase
    r.phase      = prs_phase;
    r.msg_class  = hdr_class;
    r.msg_id     = hdr_id;
    r.msg_length = hdr_len;
    return r;
  endfunction

  task automatic queue_byte(logic [7:0] b);
    rx_item_t it;
    // switch between idle and back-to-back stretches now and then
    if ($urandom_range(0, 29) == 0) sender_idle = ~sender_idle;
    it.data  = b;
    it.gap   = sender_idle ? $urandom_range(0, 14) : 0;
    it.drain = 1'b0;
    rx_q.push_back(it);
    n_queued++;
  endtask

  task automatic queue_drain();
    rx_item_t it;
    it.data  = '0;
    it.gap   = 0;
    it.drain = 1'b1;
    rx_q.push_back(it);
  endtask

  task automatic queue_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
                             frame_fault_e fault);
    logic [7:0]  body[$];
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    int unsigned pos;
    body.push_back(cls);
    body.push_back(id);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    for (int i = 0; i < int'(len); i++) body.push_back(8'($urandom_range(0, 255)));
    ck_a = '0;
    ck_b = '0;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (fault == FR_BAD_CKA) ck_a = ck_a ^ 8'($urandom_range(1, 255));
    if (fault == FR_BAD_CKB) ck_b = ck_b ^ 8'($urandom_range(1, 255));
    // corrupt one payload byte after the sums were taken
    if (fault == FR_BAD_PAYLOAD && len != 16'd0) begin
      pos = $urandom_range(4, body.size() - 1);
      body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
    end
    queue_byte(ubxfp_pkg::SYNC_FIRST);
    queue_byte(ubxfp_pkg::SYNC_SECOND);
    foreach (body[i]) queue_byte(body[i]);
    queue_byte(ck_a);
    queue_byte(ck_b);
  endtask

  // Driver: present queued bytes, predict each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : drv
    rx_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte  <= '0;
      hold_off <= 0;
    end else begin
      if (in_valid && !in_stall_o) parse_q.push_back(parse_byte(rx_byte));
      if (!in_valid || !in_stall_o) begin
        if (hold_off != 0) begin
          in_valid <= 1'b0;
          hold_off <= hold_off - 1;
        end else if (rx_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (rx_q[0].drain) begin
          // hold off until every outstanding result has been taken
          in_valid <= 1'b0;
          if (parse_q.size() == 0) nxt = rx_q.pop_front();
        end else begin
          nxt = rx_q.pop_front();
          in_valid <= 1'b1;
          rx_byte  <= nxt.data;
          hold_off <= nxt.gap;
        end
      end
    end
  end

  // Monitor: take results with random backpressure and compare
  always @(posedge clk_i or negedge rst_ni) begin : mon
    ubxfp_pkg::result_t got;
    ubxfp_pkg::result_t want;
    int unsigned        n;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall) begin
      got = '{phase_o, payload_valid_o, payload_byte_o, payload_index_o,
              msg_class_o, msg_id_o, msg_length_o, checksum_error_o};
      n_results++;
      if (got.phase == ubxfp_pkg::PH_DONE) n_complete++;
      if (got.checksum_error) n_ck_errors++;
      if (got.payload_valid) n_payload++;
      if (parse_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected result, phase %0d", $realtime, got.phase);
      end else begin
        want = parse_q.pop_front();
        if (got.phase !== want.phase || got.payload_valid !== want.payload_valid ||
            got.payload_byte !== want.payload_byte ||
            got.payload_index !== want.payload_index ||
            got.msg_class !== want.msg_class || got.msg_id !== want.msg_id ||
            got.msg_length !== want.msg_length ||
            got.checksum_error !== want.checksum_error) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%0t: result %0d mismatch", $realtime, n_results);
            $display("  exp ph=%0d pv=%0b pb=%h pi=%0d cls=%h id=%h len=%0d ce=%0b",
                     want.phase, want.payload_valid, want.payload_byte,
                     want.payload_index, want.msg_class, want.msg_id,
                     want.msg_length, want.checksum_error);
            $display("  act ph=%0d pv=%0b pb=%h pi=%0d cls=%h id=%h len=%0d ce=%0b",
                     got.phase, got.payload_valid, got.payload_byte,
                     got.payload_index, got.msg_class, got.msg_id,
                     got.msg_length, got.checksum_error);
          end
        end
      end
      if ($urandom_range(0, 29) == 0) sink_idle = ~sink_idle;
      n = sink_idle ? $urandom_range(0, 14) : 0;
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", idle_cycles);
        $display("[ubx_frame_parser_core] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stim
    int unsigned  kind;
    int unsigned  len;
    bit           big_done;
    frame_fault_e fault;
    big_done = 1'b0;

    // Zero-length frame with extreme class and id, then a new hunt right
    // after completion, and a repeated sync byte that must not resync.
    queue_frame(8'hFF, 8'h00, 16'd0, FR_GOOD);
    queue_byte(ubxfp_pkg::SYNC_FIRST);
    queue_byte(ubxfp_pkg::SYNC_FIRST);
    queue_byte(ubxfp_pkg::SYNC_SECOND);
    // One-byte payload with a bad first checksum byte
    queue_frame(8'h00, 8'hFF, 16'd1, FR_BAD_CKA);
    queue_drain();

    while (n_queued < NUM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (!big_done && n_queued > NUM_BYTES / 2) begin
        // one long payload to walk the index past the low byte
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'd300, FR_GOOD);
        big_done = 1'b1;
      end else if (kind <= 6) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        case ($urandom_range(0, 7))
          0: fault = FR_BAD_CKA;
          1: fault = FR_BAD_CKB;
          default: fault = FR_GOOD;
        endcase
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'(len), fault);
      end else if (kind == 7) begin
        queue_byte(ubxfp_pkg::SYNC_FIRST);
        queue_byte(8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 5)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(1, 16)), FR_BAD_PAYLOAD);
      end
      if ($urandom_range(0, 19) == 0) queue_drain();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for one result per streamed byte
    while (n_results < n_queued) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Streamed %0d bytes, checked %0d results", n_queued, n_results);
    $display("Frames completed %0d, checksum errors %0d, payload bytes %0d",
             n_complete, n_ck_errors, n_payload);
    if (n_errors == 0) begin
      $display("[ubx_frame_parser_core] OK");
    end else begin
      $display("%0d mismatching results", n_errors);
      $display("[ubx_frame_parser_core] ERROR");
    end
    $finish;
  end

endmodule
